// File: src/text_console_scroll_buffer_assert.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef TEXT_CONSOLE_SCROLL_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_SCROLL_BUFFER_ASSERT_SVH

// cond must hold at every edge
`define TCSB_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold at the next edge after ante
`define TCSB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tcsb_pkg.sv
package tcsb_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 2;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // register select, paddr[2]
  localparam logic REG_VISIBLE_COLS = 1'b0;
  localparam logic REG_VISIBLE_ROWS = 1'b1;

  localparam logic [7:0] VIS_COLS_RST = 8'd80;
  localparam logic [8:0] VIS_ROWS_RST = 9'd32;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [1:0] color_index;
    logic [7:0] read_row;
    logic [6:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [1:0] cell_color;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] view_top;
    logic       scrolled;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_stage_t;

endpackage

// File: src/tcsb_ram.sv
module tcsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/tcsb_ctrl.sv
`include "text_console_scroll_buffer_assert.svh"

module tcsb_ctrl
  import tcsb_pkg::*;
#(
  parameter int ROWS = 256,
  parameter int COLS = 128,
  localparam int RW  = $clog2(ROWS),
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1,
  localparam int CLW = $clog2(COLS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_word_t          in_word,
  input  logic [7:0]        vis_cols,
  input  logic [8:0]        vis_rows,
  input  logic              s1_adv,
  output logic              cell_we,
  output logic              cell_re,
  output logic [RW+CAW-1:0] cell_addr,
  output logic [CELL_W-1:0] cell_wdata,
  input  logic [CELL_W-1:0] cell_rdata,
  output logic              len_we,
  output logic              len_re,
  output logic [RW-1:0]     len_addr,
  output logic [CLW-1:0]    len_wdata,
  input  logic [CLW-1:0]    len_rdata,
  output res_stage_t        res
);

  typedef enum logic [1:0] {LEN_ZERO, LEN_CUR, LEN_MEM} len_src_t;

  localparam logic [RW:0]     ROWS_X   = (RW + 1)'(ROWS);
  localparam logic [RW-1:0]   LAST_ROW = RW'(ROWS - 1);
  localparam logic [9:0]      COLS_C   = 10'(COLS);
  localparam int              RCW      = ((RW > 8) ? RW : 8) + 1;
  localparam logic [RCW-1:0]  ROWS_R   = RCW'(ROWS);
  localparam int              VW       = ((RW > 9) ? RW : 9) + 1;

  logic [RW-1:0]  ring_base_r, ring_base_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CLW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0]  view_top_r, view_top_nxt;

  logic           s1_valid_r;
  out_word_t      s1_word_r, s1_word_nxt;
  len_src_t       s1_src_r, s1_src_nxt;
  logic [CLW-1:0] s1_len_r;
  logic [6:0]     s1_rcol_r;

  logic           is_put, is_read, wrap, open_row, put_char, bksp, scroll;
  logic [9:0]     vc_eff;
  logic [8:0]     vr_eff;
  logic [RW-1:0]  vt_dec;
  logic [VW-1:0]  row_ext, vt_lim, vt_fit;
  logic [CLW-1:0] col_base;
  logic [RW-1:0]  rrow_l, rd_phys, cur_phys, put_phys;
  logic [CAW-1:0] rcol_c;
  logic           in_range, col_ok;
  logic [CLW-1:0] len_sel;
  logic           hit;

  // logical to physical row through the ring base
  function automatic logic [RW-1:0] phys_of(logic [RW-1:0] base, logic [RW-1:0] lrow);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, lrow};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[RW-1:0];
  endfunction

  // command decode
  always_comb begin
    is_put   = accept && (in_word.command == CMD_PUT);
    is_read  = accept && (in_word.command == CMD_READ);
    vc_eff   = (vis_cols == '0 || 10'(vis_cols) > COLS_C) ? COLS_C : 10'(vis_cols);
    vr_eff   = (vis_rows == '0) ? 9'd1 : vis_rows;
    wrap     = 10'(cur_col_r) >= vc_eff;
    open_row = 1'b0;
    put_char = 1'b0;
    bksp     = 1'b0;
    if (is_put) begin
      case (in_word.char_code)
        CH_NEWLINE:   open_row = 1'b1;
        CH_RETURN:    open_row = 1'b0;
        CH_BACKSPACE: bksp = (cur_col_r != '0);
        default: begin
          open_row = wrap;
          put_char = 1'b1;
        end
      endcase
    end
  end

  // cursor, ring base and view top
  always_comb begin
    scroll        = open_row && (cur_row_r == LAST_ROW);
    ring_base_nxt = ring_base_r;
    cur_row_nxt   = cur_row_r;
    if (scroll) begin
      ring_base_nxt = (ring_base_r == LAST_ROW) ? '0 : ring_base_r + 1'b1;
    end else if (open_row) begin
      cur_row_nxt = cur_row_r + 1'b1;
    end
    vt_dec  = (scroll && view_top_r != '0) ? view_top_r - 1'b1 : view_top_r;
    row_ext = VW'(cur_row_nxt);
    vt_lim  = VW'(vt_dec) + VW'(vr_eff);
    vt_fit  = row_ext + VW'(1) - VW'(vr_eff);
    view_top_nxt = (open_row && row_ext >= vt_lim) ? vt_fit[RW-1:0] : vt_dec;

    col_base = open_row ? '0 : cur_col_r;
    if (put_char) begin
      cur_col_nxt = col_base + 1'b1;
    end else if (bksp) begin
      cur_col_nxt = cur_col_r - 1'b1;
    end else begin
      cur_col_nxt = col_base;
    end
  end

  // memory requests; the cursor row's length lives in cur_col_r and is
  // written back only when the cursor leaves the row
  always_comb begin
    rrow_l   = RW'(in_word.read_row);
    rcol_c   = CAW'(in_word.read_col);
    in_range = RCW'(in_word.read_row) < ROWS_R;
    col_ok   = 10'(in_word.read_col) < COLS_C;
    rd_phys  = phys_of(ring_base_r, rrow_l);
    cur_phys = phys_of(ring_base_r, cur_row_r);
    put_phys = phys_of(ring_base_nxt, cur_row_nxt);

    cell_we    = put_char;
    cell_re    = is_read;
    cell_addr  = is_read ? {rd_phys, rcol_c} : {put_phys, CAW'(col_base)};
    cell_wdata = {in_word.char_code, in_word.color_index};
    len_we     = open_row;
    len_re     = is_read;
    len_addr   = is_read ? rd_phys : cur_phys;
    len_wdata  = cur_col_r;

    // rows past the cursor were never opened and read as empty
    if (!is_read || !in_range || !col_ok) begin
      s1_src_nxt = LEN_ZERO;
    end else if (rrow_l == cur_row_r) begin
      s1_src_nxt = LEN_CUR;
    end else if (rrow_l < cur_row_r) begin
      s1_src_nxt = LEN_MEM;
    end else begin
      s1_src_nxt = LEN_ZERO;
    end

    s1_word_nxt            = '0;
    s1_word_nxt.cursor_row = 8'(cur_row_nxt);
    s1_word_nxt.cursor_col = 8'(cur_col_nxt);
    s1_word_nxt.view_top   = 8'(view_top_nxt);
    s1_word_nxt.scrolled   = scroll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_base_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      view_top_r  <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      ring_base_r <= ring_base_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      view_top_r  <= view_top_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= s1_word_nxt;
      s1_src_r  <= s1_src_nxt;
      s1_len_r  <= cur_col_r;
      s1_rcol_r <= in_word.read_col;
    end
  end

  // read stage: RAM data is valid now
  always_comb begin
    case (s1_src_r)
      LEN_CUR: len_sel = s1_len_r;
      LEN_MEM: len_sel = len_rdata;
      default: len_sel = '0;
    endcase
    hit       = 10'(s1_rcol_r) < 10'(len_sel);
    res.valid = s1_valid_r;
    res.word  = s1_word_r;
    if (hit) begin
      res.word.cell_char  = cell_rdata[CELL_W-1:COLOR_W];
      res.word.cell_color = cell_rdata[COLOR_W-1:0];
    end
  end

  `TCSB_CHECK(a_view_at_or_above_cursor, view_top_r <= cur_row_r, "view top below cursor row")
  `TCSB_CHECK(a_col_in_range, 10'(cur_col_r) <= COLS_C, "cursor column past COLS")
  `TCSB_CHECK_NEXT(a_scroll_holds_last_row, accept && scroll, cur_row_r == LAST_ROW && cur_col_r <= CLW'(1), "scroll left cursor off last row")
  `TCSB_CHECK_NEXT(a_read_keeps_state, is_read, $stable(cur_row_r) && $stable(cur_col_r) && $stable(ring_base_r) && $stable(view_top_r), "read changed cursor state")

endmodule

// File: src/text_console_scroll_buffer.sv
// Channel   Ports                                   Word
// input     in_valid / in_ready / in_word           in_word_t: put or read command
// output    out_valid / out_ready / out_word        out_word_t: cell, cursor, view top
// config    psel penable pwrite paddr pwdata prdata  visible_cols @0x0, visible_rows @0x4
//
// One word per cycle sustained while out_ready stays high; a result passes through the
// RAM read stage, then the output register.
// Cells and per-row line lengths sit in two single-port RAMs, each touched
// once per word, so a word never waits on another.
// Reset is synchronous: cursor, ring base and view top go to zero, no RAM sweep;
// rows past the cursor read as empty.
// The read stage stalls only while the output register is held by out_ready low.
module text_console_scroll_buffer
  import tcsb_pkg::*;
#(
  parameter int ROWS = 256,
  parameter int COLS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW  = $clog2(ROWS);
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CLW = $clog2(COLS + 1);

  logic [7:0]  vis_cols_r;
  logic [8:0]  vis_rows_r;
  logic        cfg_we;

  logic        accept, s1_adv;
  res_stage_t  res;
  logic        out_valid_r;
  out_word_t   out_word_r;

  logic              cell_we, cell_re;
  logic [RW+CAW-1:0] cell_addr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic              len_we, len_re;
  logic [RW-1:0]     len_addr;
  logic [CLW-1:0]    len_wdata, len_rdata;

  // config registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_cols_r <= VIS_COLS_RST;
      vis_rows_r <= VIS_ROWS_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_VISIBLE_COLS: vis_cols_r <= pwdata[7:0];
        REG_VISIBLE_ROWS: vis_rows_r <= pwdata[8:0];
        default:          vis_cols_r <= vis_cols_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VISIBLE_COLS: prdata = 32'(vis_cols_r);
      REG_VISIBLE_ROWS: prdata = 32'(vis_rows_r);
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !res.valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && s1_adv) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  tcsb_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_word    (in_word),
    .vis_cols   (vis_cols_r),
    .vis_rows   (vis_rows_r),
    .s1_adv     (s1_adv),
    .cell_we    (cell_we),
    .cell_re    (cell_re),
    .cell_addr  (cell_addr),
    .cell_wdata (cell_wdata),
    .cell_rdata (cell_rdata),
    .len_we     (len_we),
    .len_re     (len_re),
    .len_addr   (len_addr),
    .len_wdata  (len_wdata),
    .len_rdata  (len_rdata),
    .res        (res)
  );

  // char and color per cell, row-major with power-of-two row pitch
  tcsb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (ROWS * (2 ** CAW))
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .re    (cell_re),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  tcsb_ram #(
    .WIDTH (CLW),
    .DEPTH (ROWS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .re    (len_re),
    .addr  (len_addr),
    .wdata (len_wdata),
    .rdata (len_rdata)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import tcsb_pkg::*;
();

  localparam int NROWS = 256;
  localparam int NCOLS = 128;
  localparam int LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_scroll_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // console shadow: cells, line lengths, ring base, cursor, view top
  bit [7:0]   shadow_char [NROWS*NCOLS];
  bit [1:0]   shadow_color [NROWS*NCOLS];
  int         line_len [NROWS];
  int         base_row = 0;
  int         cur_row = 0;
  int         cur_col = 0;
  int         top_row = 0;
  logic [7:0] vis_cols = VIS_COLS_RST;
  logic [8:0] vis_rows = VIS_ROWS_RST;
  int         scroll_total = 0;

  in_word_t  pending_q [$];
  out_word_t console_q [$];
  out_word_t head;
  int        mismatches = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        cycles = 0;

  function automatic bit open_row();
    bit dropped;
    int vr;
    dropped = 1'b0;
    cur_row++;
    cur_col = 0;
    if (cur_row >= NROWS) begin
      base_row = (base_row + 1) % NROWS;
      cur_row = NROWS - 1;
      if (top_row > 0) top_row--;
      dropped = 1'b1;
    end
    line_len[(base_row + cur_row) % NROWS] = 0;
    vr = (vis_rows == 0) ? 1 : int'(vis_rows);
    if (cur_row >= top_row + vr) top_row = cur_row + 1 - vr;
    return dropped;
  endfunction

  function automatic out_word_t console_step(in_word_t w);
    out_word_t r;
    int p;
    int wrap;
    r = '0;
    if (w.command == CMD_READ) begin
      p = (base_row + int'(w.read_row)) % NROWS;
      if (int'(w.read_col) < line_len[p]) begin
        r.cell_char = shadow_char[p*NCOLS + int'(w.read_col)];
        r.cell_color = shadow_color[p*NCOLS + int'(w.read_col)];
      end
    end else if (w.char_code == CH_NEWLINE) begin
      r.scrolled = open_row();
    end else if (w.char_code == CH_RETURN) begin
    end else if (w.char_code == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        line_len[(base_row + cur_row) % NROWS] = cur_col;
      end
    end else begin
      wrap = (vis_cols == 0 || int'(vis_cols) > NCOLS) ? NCOLS : int'(vis_cols);
      if (cur_col >= wrap) r.scrolled = open_row();
      if (cur_col < NCOLS) begin
        p = (base_row + cur_row) % NROWS;
        shadow_char[p*NCOLS + cur_col] = w.char_code;
        shadow_color[p*NCOLS + cur_col] = w.color_index;
        cur_col++;
        line_len[p] = cur_col;
      end
    end
    if (r.scrolled) scroll_total++;
    r.cursor_row = cur_row[7:0];
    r.cursor_col = cur_col[7:0];
    r.view_top = top_row[7:0];
    return r;
  endfunction

  function automatic in_word_t word(logic cmd, logic [7:0] ch, logic [1:0] ci,
                                    logic [7:0] row, logic [6:0] col);
    in_word_t w;
    w.command = cmd;
    w.char_code = ch;
    w.color_index = ci;
    w.read_row = row;
    w.read_col = col;
    return w;
  endfunction

  function automatic in_word_t make_item(int rd_pct, int nl_pct);
    in_word_t w;
    int roll;
    w = word(CMD_PUT, 8'($urandom), 2'($urandom), 8'($urandom), 7'($urandom));
    roll = $urandom_range(99);
    if (roll < rd_pct) begin
      w.command = CMD_READ;
      if ($urandom_range(1) == 1) w.read_col = 7'($urandom_range(7));
      // aim reads at rows that hold text: the first ones, or the newest after scrolling
      case ($urandom_range(2))
        0: w.read_row = 8'($urandom_range(15));
        1: w.read_row = 8'(255 - $urandom_range(7));
        default: ;
      endcase
    end else begin
      roll = $urandom_range(99);
      if (roll < nl_pct) w.char_code = CH_NEWLINE;
      else if (roll < nl_pct + 4) w.char_code = CH_BACKSPACE;
      else if (roll < nl_pct + 6) w.char_code = CH_RETURN;
    end
    return w;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) console_q.push_back(console_step(in_word));
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_word <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (console_q.size() == 0) begin
          $error("result word with nothing expected: %p", out_word);
          mismatches++;
        end else begin
          head = console_q.pop_front();
          check_field("cell_char", head.cell_char, out_word.cell_char);
          check_field("cell_color", 8'(head.cell_color), 8'(out_word.cell_color));
          check_field("cursor_row", head.cursor_row, out_word.cursor_row);
          check_field("cursor_col", head.cursor_col, out_word.cursor_col);
          check_field("view_top", head.view_top, out_word.view_top);
          check_field("scrolled", 8'(head.scrolled), 8'(out_word.scrolled));
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= 150;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // checked on the falling edge so every driver update has settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || console_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_VISIBLE_COLS) vis_cols = value[7:0];
    else vis_rows = value[8:0];
  endtask

  task automatic run_phase(logic [31:0] cols, logic [31:0] rows, int s_pct, int r_pct,
                           int rd_pct, int nl_pct, int n);
    wait_idle();
    write_reg(REG_VISIBLE_COLS, cols);
    write_reg(REG_VISIBLE_ROWS, rows);
    send_idle = s_pct;
    recv_idle = r_pct;
    repeat (n) pending_q.push_back(make_item(rd_pct, nl_pct));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values, no idling
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'hFF, 2'd3, 8'd255, 7'd127));
    pending_q.push_back(word(CMD_PUT, 8'h41, 2'd3, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, 8'hFF, 2'd0, 8'd255, 7'd127));
    pending_q.push_back(word(CMD_PUT, 8'h00, 2'd1, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, 8'h7F, 2'd2, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, CH_BACKSPACE, 2'd0, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd0, 7'd2));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd0, 7'd3));
    pending_q.push_back(word(CMD_PUT, CH_RETURN, 2'd1, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, CH_NEWLINE, 2'd2, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, CH_BACKSPACE, 2'd3, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, 8'h80, 2'd3, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd1, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd2, 7'd0));
    pending_q.push_back(word(CMD_PUT, CH_NEWLINE, 2'd0, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_PUT, CH_NEWLINE, 2'd0, 8'd0, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd1, 7'd0));
    pending_q.push_back(word(CMD_READ, 8'h00, 2'd0, 8'd0, 7'd127));

    // one-column rows: nearly every put opens a row, so the buffer soon scrolls
    run_phase(32'd1, 32'd1, 27, 75, 8, 10, 40);
    hold_seq++;
    while (scroll_total < 8) begin
      wait_idle();
      repeat (40) pending_q.push_back(make_item(8, 10));
    end

    // full width, long lines up to the last column
    run_phase(32'd128, 32'd256, 27, 75, 3, 0, 160);
    // zero registers with junk in the upper bits
    run_phase(32'hABCD_EF00, 32'h1234_5E00, 75, 27, 30, 35, 50);
    run_phase(32'd255, 32'd511, 75, 27, 30, 35, 50);
    run_phase(32'd5, 32'd3, 0, 0, 30, 20, 50);
    run_phase(32'd80, 32'd32, 0, 0, 30, 25, 50);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && console_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
